// ===== hdl/rig_pkg.sv =====
// ----------------------------------------------------------------------------
// rig_pkg
// Shared widths, constants and the pipeline word type of the radical inverse
// generator.
// ----------------------------------------------------------------------------
package rig_pkg;

    localparam int unsigned IDX_W      = 32;
    localparam int unsigned FRAC_W     = 32;
    // base-3 digits of a 32-bit index: 3^20 < 2^32 <= 3^21
    localparam int unsigned NUM_DIGITS = 21;
    // q = (x * RECIP_3) >> RECIP_SHIFT is exact x / 3 for any 32-bit x
    localparam logic [IDX_W-1:0] RECIP_3     = 32'hAAAA_AAAB;
    localparam int unsigned      RECIP_SHIFT = 33;

    // base select carried in the func bit of a request word
    typedef enum logic {
        BASE_2 = 1'b0,
        BASE_3 = 1'b1
    } base_sel_t;

    typedef logic [IDX_W-1:0]  index_t;
    typedef logic [FRAC_W-1:0] frac_t;

    // one pipeline word: remaining index and the partial sample
    typedef struct packed {
        logic   valid;
        index_t idx;
        frac_t  acc;
    } stage_t;

endpackage

// ===== hdl/rig_if.sv =====
// ----------------------------------------------------------------------------
// rig_if
// Valid/ready channel interfaces of the radical inverse generator.
// ----------------------------------------------------------------------------

// request word: base select and offset
interface rig_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] offset;

    modport source (output valid, output func, output offset, input ready);
    modport sink   (input valid, input func, input offset, output ready);
endinterface

// response word: radical inverse sample
interface rig_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// configuration write: seed index
interface rig_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed_index;

    modport source (output valid, output seed_index, input ready);
    modport sink   (input valid, input seed_index, output ready);
endinterface

// ===== hdl/rig_entry_stage.sv =====
// ----------------------------------------------------------------------------
// rig_entry_stage
// Adds seed and offset, prepares the pipeline word for the selected base.
// ----------------------------------------------------------------------------
module rig_entry_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic            func,
    input  rig_pkg::index_t offset,
    input  rig_pkg::index_t seed,
    output rig_pkg::stage_t out_word
);

    logic             valid_reg;
    rig_pkg::index_t  idx_reg;
    rig_pkg::frac_t   acc_reg;
    rig_pkg::index_t  sum;
    rig_pkg::frac_t   rev;
    rig_pkg::index_t  idx_next;
    rig_pkg::frac_t   acc_next;

    assign sum = seed + offset;

    // base 2: mirror the index about the binary point
    always_comb
    begin
        rev = '0;
        for (int j = 0; j < int'(rig_pkg::FRAC_W) && j < int'(rig_pkg::IDX_W); j++)
        begin
            rev[rig_pkg::FRAC_W-1-j] = sum[j];
        end
    end

    // base 2 words carry a zero index so the digit stages leave them alone
    always_comb
    begin
        if (func == rig_pkg::BASE_3)
        begin
            idx_next = sum;
            acc_next = '0;
        end
        else
        begin
            idx_next = '0;
            acc_next = rev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg <= idx_next;
            acc_reg <= acc_next;
        end
    end

    assign out_word.valid = valid_reg;
    assign out_word.idx   = idx_reg;
    assign out_word.acc   = acc_reg;

endmodule

// ===== hdl/rig_digit_stage.sv =====
// ----------------------------------------------------------------------------
// rig_digit_stage
// Strips one base-3 digit off the index and adds its weighted value.
// ----------------------------------------------------------------------------
module rig_digit_stage
#(
    parameter int unsigned DIGIT = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  rig_pkg::stage_t in_word,
    output rig_pkg::stage_t out_word
);

    // floor(2^32 / 3^(DIGIT+1)), the same as floor((2^32-1) / 3^(DIGIT+1))
    localparam logic [63:0] POW3     = 64'd3 ** (DIGIT + 1);
    localparam logic [63:0] WEIGHT64 = 64'hFFFF_FFFF / POW3;
    localparam logic [63:0] DOUBLE64 = WEIGHT64 * 64'd2;
    localparam rig_pkg::frac_t WEIGHT1 = WEIGHT64[rig_pkg::FRAC_W-1:0];
    localparam rig_pkg::frac_t WEIGHT2 = DOUBLE64[rig_pkg::FRAC_W-1:0];

    logic [2*rig_pkg::IDX_W-1:0] prod;
    rig_pkg::index_t             quot;
    rig_pkg::index_t             triple;
    rig_pkg::index_t             diff;
    logic [1:0]                  digit;
    rig_pkg::frac_t              addend;

    logic             valid_reg;
    rig_pkg::index_t  idx_reg;
    rig_pkg::frac_t   acc_reg;

    assign prod   = {{rig_pkg::IDX_W{1'b0}}, in_word.idx}
                  * {{rig_pkg::IDX_W{1'b0}}, rig_pkg::RECIP_3};
    assign quot   = prod[2*rig_pkg::IDX_W-1 -: rig_pkg::IDX_W] >> (rig_pkg::RECIP_SHIFT
                  - rig_pkg::IDX_W);
    assign triple = quot + (quot << 1);
    assign diff   = in_word.idx - triple;
    assign digit  = diff[1:0];

    always_comb
    begin
        case (digit)
            2'd1:    addend = WEIGHT1;
            2'd2:    addend = WEIGHT2;
            default: addend = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_word.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg <= quot;
            acc_reg <= in_word.acc + addend;
        end
    end

    assign out_word.valid = valid_reg;
    assign out_word.idx   = idx_reg;
    assign out_word.acc   = acc_reg;

endmodule

// ===== hdl/radical_inverse_generator.sv =====
// ----------------------------------------------------------------------------
// radical_inverse_generator
// Van der Corput radical inverse in base 2 or 3 as a 0.32 fraction.
// ----------------------------------------------------------------------------
// Usage:
//   cfg : one write sets seed_index, added to every offset; always ready.
//         Write it only while no word is in flight.
//   req : word {func, offset}; func 0 = base 2, func 1 = base 3.
//   rsp : word {sample}; sample / 2^32 is the radical inverse of
//         (seed_index + offset) mod 2^32.
// Timing:
//   An accepted req word passes through one entry stage
//   (seed add, bit reversal) then 21 digit stages, one per base-3 digit,
//   each built around one 32x32 reciprocal multiply, to its rsp word.
//   One word per cycle sustained while rsp does not stall.
// Reset:
//   rst_n clears seed_index and every stage valid; no word is in flight.
// Stall:
//   All stages advance together while the output stage is empty or rsp is
//   taken; when rsp stalls with a word held, the whole pipeline holds and
//   req.ready drops. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module radical_inverse_generator
(
    input  logic       clk,
    input  logic       rst_n,
    rig_cfg_if.sink    cfg,
    rig_req_if.sink    req,
    rig_rsp_if.source  rsp
);

    localparam int unsigned LAST = rig_pkg::NUM_DIGITS;

    rig_pkg::index_t seed_reg;
    rig_pkg::stage_t stg [0:LAST];
    logic            adv;

    // seed register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg.valid)
        begin
            seed_reg <= cfg.seed_index;
        end
    end

    // global advance: output stage free or being drained
    assign adv       = !stg[LAST].valid || rsp.ready;
    assign req.ready = adv;

    rig_entry_stage u_entry
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (req.valid),
        .func     (req.func),
        .offset   (req.offset),
        .seed     (seed_reg),
        .out_word (stg[0])
    );

    // one stage per base-3 digit, least significant first
    for (genvar k = 0; k < int'(rig_pkg::NUM_DIGITS); k++)
    begin : g_digit
        rig_digit_stage
        #(
            .DIGIT (k)
        )
        u_digit
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_word  (stg[k]),
            .out_word (stg[k+1])
        );
    end

    assign rsp.valid  = stg[LAST].valid;
    assign rsp.sample = stg[LAST].acc;

endmodule
